### src/mtq_pkg.sv
// Shared types and constants for the mismatch table with earliest query.
package mtq_pkg;

    localparam int ACT_W    = 2;
    localparam int BLOCK_W  = 48;
    localparam int COMMIT_W = 32;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_MINSCAN,
        S_REPORT
    } t_state;

    // One table entry; a block number of zero marks the slot as empty.
    typedef struct packed {
        logic [BLOCK_W-1:0]  blk;
        logic [COMMIT_W-1:0] cid;
    } t_slot;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic cnt_step;
        logic mem_clear;
        logic eval_lookup;
        logic eval_min;
        logic update;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic cnt_end;
        logic scan_done;
    } t_stat;

endpackage

### src/mtq_datapath.sv
// Slot memory, scan counter, lookup and minimum trackers, and result registers.
module mtq_datapath #(
    parameter int SLOTS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtq_pkg::t_cmd                 i_cmd,
    output mtq_pkg::t_stat                o_stat,
    input  logic [mtq_pkg::ACT_W-1:0]     i_action,
    input  logic [mtq_pkg::BLOCK_W-1:0]   i_block_number,
    input  logic [mtq_pkg::COMMIT_W-1:0]  i_commit_id,
    output logic                          o_found,
    output logic [mtq_pkg::COMMIT_W-1:0]  o_earliest_commit,
    output logic [mtq_pkg::BLOCK_W-1:0]   o_earliest_block,
    output logic                          o_overflow
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    mtq_pkg::t_slot r_mem [SLOTS];
    mtq_pkg::t_slot r_rd;

    logic [CW-1:0]                 r_cnt;
    logic                          r_pv;
    logic [IW-1:0]                 r_pidx;
    logic [mtq_pkg::ACT_W-1:0]     r_act;
    logic [mtq_pkg::BLOCK_W-1:0]   r_blk;
    logic [mtq_pkg::COMMIT_W-1:0]  r_cid;
    logic                          r_match_hit;
    logic [IW-1:0]                 r_match_idx;
    logic                          r_free_hit;
    logic [IW-1:0]                 r_free_idx;
    logic                          r_min_hit;
    logic [mtq_pkg::COMMIT_W-1:0]  r_min_cid;
    logic [mtq_pkg::BLOCK_W-1:0]   r_min_blk;
    logic                          r_ovf;

    logic                 in_range;
    logic [IW-1:0]        addr;
    logic                 issue;
    logic                 we;
    logic [IW-1:0]        waddr;
    mtq_pkg::t_slot       wdata;
    logic                 key_live;
    logic                 ovf_set;
    logic                 occupied;

    assign in_range = r_cnt < CW'(SLOTS);
    assign addr     = r_cnt[IW-1:0];
    assign issue    = i_cmd.cnt_step && in_range;
    assign key_live = r_blk != '0;
    assign occupied = r_rd.blk != '0;

    // One write port shared by the clearing pass and the update step.
    always_comb begin
        we      = 1'b0;
        waddr   = addr;
        wdata   = '0;
        ovf_set = 1'b0;
        if (i_cmd.mem_clear) begin
            we = in_range;
        end else if (i_cmd.update && key_live) begin
            if (r_act == mtq_pkg::ACT_INSERT) begin
                wdata.blk = r_blk;
                wdata.cid = r_cid;
                if (r_match_hit) begin
                    we    = 1'b1;
                    waddr = r_match_idx;
                end else if (r_free_hit) begin
                    we    = 1'b1;
                    waddr = r_free_idx;
                end else begin
                    ovf_set = 1'b1;
                end
            end else if (r_act == mtq_pkg::ACT_REMOVE) begin
                we    = r_match_hit;
                waddr = r_match_idx;
                wdata.cid = r_cid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_pv <= issue && !i_cmd.mem_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= addr;
        if (i_cmd.load) begin
            r_act       <= i_action;
            r_blk       <= i_block_number;
            r_cid       <= i_commit_id;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_cmd.eval_lookup && r_pv) begin
                if (!r_match_hit && r_rd.blk == r_blk) begin
                    r_match_hit <= 1'b1;
                    r_match_idx <= r_pidx;
                end
                if (!r_free_hit && !occupied) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= r_pidx;
                end
            end
            if (ovf_set) begin
                r_ovf <= 1'b1;
            end
        end
        // Strict compare keeps the lowest slot on a tie.
        if (i_cmd.cnt_clr) begin
            r_min_hit <= 1'b0;
            r_min_cid <= '0;
            r_min_blk <= '0;
        end else if (i_cmd.eval_min && r_pv && occupied) begin
            if (!r_min_hit || r_min_cid > r_rd.cid) begin
                r_min_hit <= 1'b1;
                r_min_cid <= r_rd.cid;
                r_min_blk <= r_rd.blk;
            end
        end
    end

    assign o_stat.cnt_end   = !in_range;
    assign o_stat.scan_done = !in_range && !r_pv;

    assign o_found           = r_min_hit;
    assign o_earliest_commit = r_min_cid;
    assign o_earliest_block  = r_min_blk;
    assign o_overflow        = r_ovf;

endmodule

### src/mtq_ctrl.sv
// Controller state machine that sequences clearing, lookup, update and minimum scan.
module mtq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  mtq_pkg::t_stat  i_stat,
    output logic            busy,
    output mtq_pkg::t_cmd   o_cmd
);

    mtq_pkg::t_state r_state;
    mtq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtq_pkg::S_CLEAR: begin
                if (i_stat.cnt_end) n_state = mtq_pkg::S_IDLE;
            end
            mtq_pkg::S_IDLE: begin
                if (start) n_state = mtq_pkg::S_LOOKUP;
            end
            mtq_pkg::S_LOOKUP: begin
                if (i_stat.scan_done) n_state = mtq_pkg::S_UPDATE;
            end
            mtq_pkg::S_UPDATE: begin
                n_state = mtq_pkg::S_MINSCAN;
            end
            mtq_pkg::S_MINSCAN: begin
                if (i_stat.scan_done) n_state = mtq_pkg::S_REPORT;
            end
            mtq_pkg::S_REPORT: begin
                n_state = mtq_pkg::S_IDLE;
            end
            default: n_state = mtq_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            mtq_pkg::S_CLEAR: begin
                o_cmd.mem_clear = 1'b1;
                o_cmd.cnt_step  = 1'b1;
            end
            mtq_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.load    = start;
                o_cmd.cnt_clr = start;
            end
            mtq_pkg::S_LOOKUP: begin
                o_cmd.cnt_step    = 1'b1;
                o_cmd.eval_lookup = 1'b1;
            end
            mtq_pkg::S_UPDATE: begin
                o_cmd.update  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            mtq_pkg::S_MINSCAN: begin
                o_cmd.cnt_step = 1'b1;
                o_cmd.eval_min = 1'b1;
            end
            mtq_pkg::S_REPORT: begin
                o_cmd.report = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### src/mismatch_table_with_earliest_query.sv
// Top level of the mismatch table with earliest query.
// A transfer is accepted when start is high and busy is low. Each item runs
// through a read pass over the slot memory to find a matching or free slot,
// one write step, a second read pass to find the smallest commit ID, and one
// cycle in which o_valid is high. Each read pass steps through the slots in
// order, with a registered read and an end check. busy falls in the cycle
// after the result, so a new transfer is not accepted until the last one is
// through. o_valid is high for that one cycle only, and the receiver cannot
// stall it. After reset a clearing pass empties the table, and busy stays
// high until it has finished.
module mismatch_table_with_earliest_query #(
    parameter int SLOTS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mtq_pkg::ACT_W-1:0]     i_action,
    input  logic [mtq_pkg::BLOCK_W-1:0]   i_block_number,
    input  logic [mtq_pkg::COMMIT_W-1:0]  i_commit_id,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [mtq_pkg::COMMIT_W-1:0]  o_earliest_commit,
    output logic [mtq_pkg::BLOCK_W-1:0]   o_earliest_block,
    output logic                          o_overflow
);

    mtq_pkg::t_cmd  w_cmd;
    mtq_pkg::t_stat w_stat;

    mtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    mtq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_action          (i_action),
        .i_block_number    (i_block_number),
        .i_commit_id       (i_commit_id),
        .o_found           (o_found),
        .o_earliest_commit (o_earliest_commit),
        .o_earliest_block  (o_earliest_block),
        .o_overflow        (o_overflow)
    );

    assign o_valid = w_cmd.report;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a transfer");

    a_report_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after delivering a result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_earliest_commit == '0 && o_earliest_block == '0)
        else $error("empty table reported a nonzero entry");

    a_found_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_earliest_block != '0)
        else $error("earliest slot reported with block number zero");

endmodule
